@@ sv/dsc_pkg.sv @@
// ----------------------------------------------------------------------------
// dsc_pkg
// Types and constants shared by the diagnostic session controller.
// ----------------------------------------------------------------------------
package dsc_pkg;

	localparam int unsigned OPCODE_W   = 2;
	localparam int unsigned LENGTH_W   = 12;
	localparam int unsigned BYTE_W     = 8;
	localparam int unsigned SESSION_W  = 7;
	localparam int unsigned TIMER_W    = 16;
	localparam int unsigned P2_W       = 16;
	localparam int unsigned P2X_CFG_W  = 20;
	localparam int unsigned P2X_OUT_W  = 16;
	localparam int unsigned STATUS_W   = 2;
	localparam int unsigned REPLY_W    = 3;
	localparam int unsigned CFG_IDX_W  = 2;
	localparam int unsigned CFG_DATA_W = 20;

	typedef enum logic [OPCODE_W-1:0] {
		OP_REQUEST   = 2'd0,
		OP_KEEPALIVE = 2'd1,
		OP_TICK      = 2'd2,
		OP_UNUSED    = 2'd3
	} opcode_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_POSITIVE   = 2'd0,
		ST_BAD_LENGTH = 2'd1,
		ST_COND_FAIL  = 2'd2
	} status_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_S3_TIMEOUT = 2'd0,
		CFG_P2_SERVER  = 2'd1,
		CFG_P2X_SERVER = 2'd2
	} cfg_index_t;

	localparam logic [SESSION_W-1:0] SESS_DEFAULT     = 7'd1;
	localparam logic [SESSION_W-1:0] SESS_PROGRAMMING = 7'd2;
	localparam logic [SESSION_W-1:0] SESS_EXTENDED    = 7'd3;

	localparam logic [LENGTH_W-1:0] REQ_LENGTH        = 12'd2;
	localparam logic [TIMER_W-1:0]  DEFAULT_RELOAD_MS = 16'd100;
	localparam logic [REPLY_W-1:0]  POS_REPLY_LENGTH  = 3'd5;

	localparam logic [TIMER_W-1:0]   S3_RESET       = 16'd5000;
	localparam logic [P2_W-1:0]      P2_RESET       = 16'd50;
	// 5000 ms divided by ten
	localparam logic [P2X_OUT_W-1:0] P2X_DIV_RESET  = 16'd500;

	// x / 10 == (x * 838861) >> 23 for every x below 2^22
	localparam int unsigned          DIV10_SHIFT = 23;
	localparam logic [P2X_CFG_W-1:0] DIV10_MULT  = 20'd838861;

	function automatic logic [P2X_OUT_W-1:0] div10_sat(input logic [P2X_CFG_W-1:0] x);
		logic [2*P2X_CFG_W-1:0] prod;
		logic [2*P2X_CFG_W-DIV10_SHIFT-1:0] quo;
		prod = {{P2X_CFG_W{1'b0}}, x} * {{P2X_CFG_W{1'b0}}, DIV10_MULT};
		quo  = prod[2*P2X_CFG_W-1:DIV10_SHIFT];
		if (|quo[2*P2X_CFG_W-DIV10_SHIFT-1:P2X_OUT_W])
			return {P2X_OUT_W{1'b1}};
		return quo[P2X_OUT_W-1:0];
	endfunction

endpackage

@@ sv/diagnostic_session_control.sv @@
// ----------------------------------------------------------------------------
// diagnostic_session_control
// Session controller with S3 inactivity countdown, tester-present and tick.
// ----------------------------------------------------------------------------
//  channel | direction | handshake          | payload
//  in      | to block  | in_valid/in_stall  | opcode, request_length, bytes
//  out     | from block| out_valid/out_stall| status, session, P2, P2*, flags
//  cfg     | to block  | cfg_we             | cfg_index, cfg_wdata
//
// One item per cycle when the result is not stalled; each item passes
// through input register, then result register. Session and timer update
// as the item moves into the result register. P2*/10 is computed when the
// register is written. Reset gives the default session with the timer
// stopped. A stalled result holds the input register, which then stalls in.
// ----------------------------------------------------------------------------
module diagnostic_session_control
	import dsc_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,

	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_wdata,

	input  logic                  in_valid,
	output logic                  in_stall,
	input  logic [OPCODE_W-1:0]   opcode,
	input  logic [LENGTH_W-1:0]   request_length,
	input  logic [BYTE_W-1:0]     service_byte,
	input  logic [BYTE_W-1:0]     subfunction_byte,

	output logic                  out_valid,
	input  logic                  out_stall,
	output logic [STATUS_W-1:0]   status,
	output logic [SESSION_W-1:0]  session_out,
	output logic [P2_W-1:0]       p2_out,
	output logic [P2X_OUT_W-1:0]  p2x_out,
	output logic [REPLY_W-1:0]    reply_length,
	output logic                  lock_security,
	output logic                  timeout_reset
);

	// configuration
	logic [TIMER_W-1:0]   s3_q;
	logic [P2_W-1:0]      p2_q;
	logic [P2X_OUT_W-1:0] p2x_div_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s3_q      <= S3_RESET;
			p2_q      <= P2_RESET;
			p2x_div_q <= P2X_DIV_RESET;
		end else if (cfg_we) begin
			case (cfg_index_t'(cfg_index))
				CFG_S3_TIMEOUT: s3_q      <= cfg_wdata[TIMER_W-1:0];
				CFG_P2_SERVER:  p2_q      <= cfg_wdata[P2_W-1:0];
				CFG_P2X_SERVER: p2x_div_q <= div10_sat(cfg_wdata[P2X_CFG_W-1:0]);
				default: ;
			endcase
		end
	end

	// input register
	logic                 valid_s1;
	logic [OPCODE_W-1:0]  opcode_s1;
	logic [LENGTH_W-1:0]  length_s1;
	logic [SESSION_W-1:0] sub_s1;
	logic                 advance;

	assign advance  = valid_s1 && (!out_valid || !out_stall);
	assign in_stall = valid_s1 && !advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	// service byte is carried on the channel but has no effect
	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			opcode_s1 <= opcode;
			length_s1 <= request_length;
			sub_s1    <= subfunction_byte[SESSION_W-1:0];
		end
	end

	// session state
	logic [SESSION_W-1:0] session_q;
	logic [TIMER_W-1:0]   count_q;
	logic                 running_q;

	logic [SESSION_W-1:0] nxt_session;
	logic [TIMER_W-1:0]   nxt_count;
	logic                 nxt_running;
	status_t              nxt_status;
	logic                 positive;
	logic                 nxt_lock;
	logic                 nxt_treset;
	logic                 refused;

	always_comb begin
		nxt_session = session_q;
		nxt_count   = count_q;
		nxt_running = running_q;
		nxt_status  = ST_POSITIVE;
		positive    = 1'b0;
		nxt_lock    = 1'b0;
		nxt_treset  = 1'b0;
		refused     = ((sub_s1 == SESS_PROGRAMMING) && (session_q == SESS_DEFAULT)) ||
		              ((sub_s1 == SESS_EXTENDED) && (session_q == SESS_PROGRAMMING));
		case (opcode_t'(opcode_s1))
			OP_REQUEST: begin
				if (length_s1 != REQ_LENGTH) begin
					nxt_status = ST_BAD_LENGTH;
				end else if (sub_s1 == session_q) begin
					if (sub_s1 == SESS_PROGRAMMING || sub_s1 == SESS_EXTENDED) begin
						nxt_count   = s3_q;
						nxt_running = 1'b1;
					end
					positive = 1'b1;
				end else begin
					nxt_lock = 1'b1;
					if (refused) begin
						nxt_status = ST_COND_FAIL;
					end else begin
						nxt_session = sub_s1;
						nxt_count   = (sub_s1 == SESS_DEFAULT) ? DEFAULT_RELOAD_MS : s3_q;
						nxt_running = 1'b1;
						positive    = 1'b1;
					end
				end
			end
			OP_KEEPALIVE: begin
				if (session_q != SESS_DEFAULT) begin
					nxt_count   = s3_q;
					nxt_running = 1'b1;
				end
			end
			OP_TICK: begin
				if (running_q) begin
					if (count_q <= TIMER_W'(1)) begin
						nxt_count   = '0;
						nxt_running = 1'b0;
						nxt_session = SESS_DEFAULT;
						nxt_lock    = 1'b1;
						nxt_treset  = 1'b1;
					end else begin
						nxt_count = count_q - TIMER_W'(1);
					end
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			session_q <= SESS_DEFAULT;
			count_q   <= '0;
			running_q <= 1'b0;
		end else if (advance) begin
			session_q <= nxt_session;
			count_q   <= nxt_count;
			running_q <= nxt_running;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (!out_valid || !out_stall) begin
			out_valid <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			status        <= nxt_status;
			session_out   <= nxt_session;
			p2_out        <= positive ? p2_q : '0;
			p2x_out       <= positive ? p2x_div_q : '0;
			reply_length  <= positive ? POS_REPLY_LENGTH : '0;
			lock_security <= nxt_lock;
			timeout_reset <= nxt_treset;
		end
	end

`ifndef SYNTH
	a_expiry_flags: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && timeout_reset |-> lock_security && session_out == SESS_DEFAULT)
		else $error("timeout without relock or default session");

	// keep-alive and tick results carry status zero with no reply bytes
	a_reply_len: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (reply_length != '0) |->
			(reply_length == POS_REPLY_LENGTH) && (status == ST_POSITIVE))
		else $error("reply length disagrees with status");

	a_timer_stop: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(running_q) |-> session_q == SESS_DEFAULT && count_q == '0)
		else $error("timer stopped outside of expiry");

	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> valid_s1 && out_valid && out_stall)
		else $error("input stalled without a held result");
`endif

endmodule
